/* rtl/stcd_pkg.sv */
// Shared types and constants for the scaled texture column draw unit.
// No dependencies; used by every module under rtl/.
package stcd_pkg;

  localparam int TEXEL_DEPTH = 4096;
  localparam int TEXEL_AW    = $clog2(TEXEL_DEPTH);
  localparam int SHADE_DEPTH = 256;
  localparam int SHADE_AW    = $clog2(SHADE_DEPTH);
  localparam int MAX_RUN     = 64;
  localparam int FRAC_BITS   = 16;
  localparam int POS_W       = FRAC_BITS + TEXEL_AW;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 12;
  localparam int VAL_W    = 8;
  localparam int FRAC_W   = 28;
  localparam int LEN_W    = 7;
  localparam int COORD_W  = 12;
  localparam int Y_W      = 13;
  localparam int ADDR_W   = 26;
  localparam int FB_W     = 24;
  localparam int SW_W     = 13;

  localparam int S_DATA_W = 136;
  localparam int M_DATA_W = 64;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam int QDEPTH   = 2;
  localparam int QAW      = $clog2(QDEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic REG_FRAME_BASE   = 1'b0;
  localparam logic REG_SCREEN_WIDTH = 1'b1;

  localparam logic [FB_W-1:0] FRAME_BASE_RESET   = '0;
  localparam logic [SW_W-1:0] SCREEN_WIDTH_RESET = SW_W'(320);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_TEXEL = 2'd0,
    CMD_LOAD_SHADE = 2'd1,
    CMD_DRAW_PLAIN = 2'd2,
    CMD_DRAW_LIT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_RUN
  } back_state_t;

  typedef struct packed {
    cmd_t                kind;
    logic [IDX_W-1:0]    load_index;
    logic [VAL_W-1:0]    load_value;
    logic [IDX_W-1:0]    source_offset;
    logic [FRAC_W-1:0]   start_fraction;
    logic [FRAC_W-1:0]   step;
    logic [LEN_W-1:0]    length;
    logic [COORD_W-1:0]  column;
    logic [Y_W-1:0]      row_start;
  } queue_entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   write_address;
    logic [VAL_W-1:0]    pixel;
    logic [COORD_W-1:0]  pixel_x;
    logic [Y_W-1:0]      pixel_y;
    logic                last;
  } pix_t;

endpackage

/* rtl/stcd_front.sv */
// Front end: accepts stream transactions, classifies commands, feeds the command queue.
// Depends on stcd_pkg.
module stcd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata, low bit up: load_index, load_value, source_offset, start_fraction,
  // step, length, column, row_top, row_shift, zero fill
  input  logic [stcd_pkg::S_DATA_W-1:0]       s_tdata,
  // s_tuser: command
  input  logic [stcd_pkg::CMD_W-1:0]          s_tuser,
  output logic                                q_valid,
  output stcd_pkg::queue_entry_t              q_entry,
  input  logic                                q_pop
);

  stcd_pkg::queue_entry_t               entry_in;
  stcd_pkg::queue_entry_t               qmem [stcd_pkg::QDEPTH];
  logic [stcd_pkg::QAW-1:0]             wr_ptr;
  logic [stcd_pkg::QAW-1:0]             rd_ptr;
  logic [stcd_pkg::QAW:0]               count;
  logic [stcd_pkg::LEN_W-1:0]           len_raw;
  logic                                 is_draw;
  logic                                 drop;
  logic                                 push;

  always_comb begin
    len_raw                 = s_tdata[94:88];
    entry_in.kind           = stcd_pkg::cmd_t'(s_tuser);
    entry_in.load_index     = s_tdata[11:0];
    entry_in.load_value     = s_tdata[19:12];
    entry_in.source_offset  = s_tdata[31:20];
    entry_in.start_fraction = s_tdata[59:32];
    entry_in.step           = s_tdata[87:60];
    entry_in.length         = (len_raw > stcd_pkg::LEN_W'(stcd_pkg::MAX_RUN)) ?
                              stcd_pkg::LEN_W'(stcd_pkg::MAX_RUN) : len_raw;
    entry_in.column         = s_tdata[106:95];
    entry_in.row_start      = stcd_pkg::Y_W'(s_tdata[118:107]) +
                              stcd_pkg::Y_W'(s_tdata[130:119]);
    is_draw = (entry_in.kind == stcd_pkg::CMD_DRAW_PLAIN) ||
              (entry_in.kind == stcd_pkg::CMD_DRAW_LIT);
    drop    = is_draw && (len_raw == '0);
  end

  assign s_tready = (count != (stcd_pkg::QAW+1)'(stcd_pkg::QDEPTH));
  assign push     = s_tvalid && s_tready && !drop;
  assign q_valid  = (count != '0);
  assign q_entry  = qmem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/stcd_back.sv */
// Back end: executes loads into the texel store and shade table, walks draw segments,
// and buffers finished pixels in an output queue. Depends on stcd_pkg.
module stcd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  stcd_pkg::queue_entry_t            q_entry,
  output logic                              q_pop,
  input  logic [stcd_pkg::FB_W-1:0]         frame_base,
  input  logic [stcd_pkg::SW_W-1:0]         screen_width,
  output logic                              out_valid,
  input  logic                              out_ready,
  output stcd_pkg::pix_t                    out_pix
);

  stcd_pkg::back_state_t                state;
  stcd_pkg::back_state_t                state_next;

  logic [stcd_pkg::VAL_W-1:0]           texel_mem [stcd_pkg::TEXEL_DEPTH];
  logic [stcd_pkg::VAL_W-1:0]           shade_mem [stcd_pkg::SHADE_DEPTH];

  logic [stcd_pkg::IDX_W-1:0]           src;
  logic [stcd_pkg::POS_W-1:0]           pos;
  logic [stcd_pkg::POS_W-1:0]           step;
  logic [stcd_pkg::LEN_W-1:0]           left;
  logic [stcd_pkg::COORD_W-1:0]         col;
  logic [stcd_pkg::Y_W-1:0]             y;
  logic [stcd_pkg::ADDR_W-1:0]          addr;
  logic                                 lit;
  logic [stcd_pkg::ADDR_W-1:0]          row_prod;

  logic                                 v0;
  logic                                 v1;
  logic                                 v2;
  logic [stcd_pkg::TEXEL_AW-1:0]        s0_tidx;
  logic                                 s0_lit;
  logic                                 s1_lit;
  logic                                 s2_lit;
  stcd_pkg::pix_t                       s0_meta;
  stcd_pkg::pix_t                       s1_meta;
  stcd_pkg::pix_t                       s2_meta;
  logic [stcd_pkg::VAL_W-1:0]           tex_q;
  logic [stcd_pkg::VAL_W-1:0]           tex_d2;
  logic [stcd_pkg::VAL_W-1:0]           shade_q;

  stcd_pkg::pix_t                       oq [stcd_pkg::OQ_DEPTH];
  logic [stcd_pkg::OQ_AW-1:0]           oq_wr;
  logic [stcd_pkg::OQ_AW-1:0]           oq_rd;
  logic [stcd_pkg::OQ_CNT_W-1:0]        oq_cnt;
  logic [stcd_pkg::OQ_CNT_W:0]          inflight;
  logic                                 issue_ok;
  logic                                 issue;
  logic                                 pipe_empty;
  logic                                 is_draw;
  logic                                 oq_push;
  logic                                 oq_pop;
  stcd_pkg::pix_t                       push_pix;

  assign is_draw    = (q_entry.kind == stcd_pkg::CMD_DRAW_PLAIN) ||
                      (q_entry.kind == stcd_pkg::CMD_DRAW_LIT);
  assign pipe_empty = !v0 && !v1;
  assign inflight   = (stcd_pkg::OQ_CNT_W+1)'(v0) + (stcd_pkg::OQ_CNT_W+1)'(v1) +
                      (stcd_pkg::OQ_CNT_W+1)'(v2) + (stcd_pkg::OQ_CNT_W+1)'(oq_cnt);
  assign issue_ok   = inflight < (stcd_pkg::OQ_CNT_W+1)'(stcd_pkg::OQ_DEPTH);
  assign row_prod   = stcd_pkg::ADDR_W'(y) * stcd_pkg::ADDR_W'(screen_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stcd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    issue      = 1'b0;
    case (state)
      stcd_pkg::S_IDLE: begin
        if (q_valid) begin
          if (is_draw) begin
            q_pop      = 1'b1;
            state_next = stcd_pkg::S_PREP;
          end else if (pipe_empty) begin
            q_pop = 1'b1;
          end
        end
      end
      stcd_pkg::S_PREP: begin
        state_next = stcd_pkg::S_RUN;
      end
      stcd_pkg::S_RUN: begin
        if (issue_ok) begin
          issue = 1'b1;
          if (left == stcd_pkg::LEN_W'(1)) begin
            state_next = stcd_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = stcd_pkg::S_IDLE;
      end
    endcase
  end

  // segment walker
  always_ff @(posedge clk) begin
    if (q_pop && is_draw) begin
      src  <= q_entry.source_offset;
      pos  <= q_entry.start_fraction[stcd_pkg::POS_W-1:0];
      step <= q_entry.step[stcd_pkg::POS_W-1:0];
      left <= q_entry.length;
      col  <= q_entry.column;
      y    <= q_entry.row_start;
      lit  <= (q_entry.kind == stcd_pkg::CMD_DRAW_LIT);
    end else if (state == stcd_pkg::S_PREP) begin
      addr <= stcd_pkg::ADDR_W'(frame_base) + stcd_pkg::ADDR_W'(col) + row_prod;
    end else if (issue) begin
      pos  <= pos + step;
      addr <= addr + stcd_pkg::ADDR_W'(screen_width);
      y    <= y + 1'b1;
      left <= left - 1'b1;
    end
  end

  // issue stage
  always_ff @(posedge clk) begin
    if (issue) begin
      s0_tidx               <= stcd_pkg::TEXEL_AW'(src) +
                               pos[stcd_pkg::POS_W-1:stcd_pkg::FRAC_BITS];
      s0_lit                <= lit;
      s0_meta.write_address <= addr;
      s0_meta.pixel         <= '0;
      s0_meta.pixel_x       <= col;
      s0_meta.pixel_y       <= y;
      s0_meta.last          <= (left == stcd_pkg::LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_entry.kind == stcd_pkg::CMD_LOAD_TEXEL)) begin
      texel_mem[q_entry.load_index[stcd_pkg::TEXEL_AW-1:0]] <= q_entry.load_value;
    end
    tex_q <= texel_mem[s0_tidx];
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_entry.kind == stcd_pkg::CMD_LOAD_SHADE)) begin
      shade_mem[q_entry.load_index[stcd_pkg::SHADE_AW-1:0]] <= q_entry.load_value;
    end
    shade_q <= shade_mem[tex_q];
  end

  always_ff @(posedge clk) begin
    s1_meta <= s0_meta;
    s1_lit  <= s0_lit;
    s2_meta <= s1_meta;
    s2_lit  <= s1_lit;
    tex_d2  <= tex_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= issue;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_comb begin
    push_pix       = s2_meta;
    push_pix.pixel = s2_lit ? shade_q : tex_d2;
  end

  assign oq_push   = v2;
  assign oq_pop    = out_valid && out_ready;
  assign out_valid = (oq_cnt != '0);
  assign out_pix   = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr] <= push_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= '0;
      oq_rd  <= '0;
      oq_cnt <= '0;
    end else begin
      if (oq_push) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      case ({oq_push, oq_pop})
        2'b10:   oq_cnt <= oq_cnt + 1'b1;
        2'b01:   oq_cnt <= oq_cnt - 1'b1;
        default: oq_cnt <= oq_cnt;
      endcase
    end
  end

endmodule

/* rtl/scaled_texture_column_draw_unit.sv */
// A draw is popped from the command queue and passes through the S_PREP setup state; in S_RUN
// the back end then issues a pixel whenever the output queue has room for it and every pixel
// still in the pipeline, so issue pauses even with m_tready high until a pixel leaves the queue.
// A load is taken in S_IDLE once earlier pixels have finished their texel and shade reads.
// Reset (rst, synchronous): queues empty, frame_base 0, screen_width 320; the texel store
// and shade table are not cleared and hold nothing defined until loaded.
module scaled_texture_column_draw_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata, low bit up: load_index, load_value, source_offset, start_fraction,
  // step, length, column, row_top, row_shift, zero fill
  input  logic [stcd_pkg::S_DATA_W-1:0]       s_tdata,
  // s_tuser: command
  input  logic [stcd_pkg::CMD_W-1:0]          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata, low bit up: write_address, pixel, pixel_x, pixel_y, zero fill
  output logic [stcd_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                                m_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stcd_pkg::PADDR_W-1:0]        paddr,
  input  logic [stcd_pkg::PDATA_W-1:0]        pwdata,
  output logic [stcd_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  logic [stcd_pkg::FB_W-1:0]   frame_base;
  logic [stcd_pkg::SW_W-1:0]   screen_width;
  logic                        q_valid;
  logic                        q_pop;
  stcd_pkg::queue_entry_t      q_entry;
  stcd_pkg::pix_t              out_pix;
  logic                        reg_sel;
  logic                        cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base   <= stcd_pkg::FRAME_BASE_RESET;
      screen_width <= stcd_pkg::SCREEN_WIDTH_RESET;
    end else if (cfg_we) begin
      if (reg_sel == stcd_pkg::REG_FRAME_BASE) begin
        frame_base <= pwdata[stcd_pkg::FB_W-1:0];
      end else begin
        screen_width <= pwdata[stcd_pkg::SW_W-1:0];
      end
    end
  end

  assign prdata = (reg_sel == stcd_pkg::REG_SCREEN_WIDTH) ?
                  stcd_pkg::PDATA_W'(screen_width) : stcd_pkg::PDATA_W'(frame_base);

  stcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  stcd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .frame_base   (frame_base),
    .screen_width (screen_width),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_pix      (out_pix)
  );

  assign m_tdata = {5'b0, out_pix.pixel_y, out_pix.pixel_x, out_pix.pixel,
                    out_pix.write_address};
  assign m_tlast = out_pix.last;

endmodule

/* tb/scaled_texture_column_draw_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for scaled_texture_column_draw_unit: a directed table, then random
// loads and column draws over several register settings, each pixel checked against the table or a predictor.
// Depends on rtl/stcd_pkg.sv and rtl/scaled_texture_column_draw_unit.sv.
module scaled_texture_column_draw_unit_tb;
  import stcd_pkg::*;

  localparam int LIMIT  = 3000000;
  localparam int SETTLE = 12;
  localparam int NRAND  = 16;
  localparam logic [IDX_W-1:0] WIN_BASE = 12'hFF0;

  typedef struct packed {
    cmd_t                kind;
    logic [IDX_W-1:0]    load_index;
    logic [VAL_W-1:0]    load_value;
    logic [IDX_W-1:0]    source_offset;
    logic [FRAC_W-1:0]   start_fraction;
    logic [FRAC_W-1:0]   step;
    logic [LEN_W-1:0]    length;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row_top;
    logic [COORD_W-1:0]  row_shift;
  } col_cmd_t;

  typedef struct packed {
    col_cmd_t c;
    logic     chk;
    pix_t     want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0]    s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic [VAL_W-1:0] texels [TEXEL_DEPTH];
  bit               texel_set [TEXEL_DEPTH];
  logic [VAL_W-1:0] shades [SHADE_DEPTH];
  bit               shade_set [SHADE_DEPTH];
  logic [FB_W-1:0]  fb_cfg = FRAME_BASE_RESET;
  logic [SW_W-1:0]  sw_cfg = SCREEN_WIDTH_RESET;

  pix_t     pixel_q [$];
  dir_row_t dir_tab [$];
  int       errors = 0;
  int       cycles = 0;
  int       stall_left = 0;
  bit       send_gaps = 1'b1;
  bit       sink_gaps = 1'b1;

  scaled_texture_column_draw_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAIL scaled_texture_column_draw_unit");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic string fmt_pix(input pix_t p);
    return $sformatf("addr=%07h pix=%02h x=%0d y=%0d last=%0b",
                     p.write_address, p.pixel, p.pixel_x, p.pixel_y, p.last);
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  function automatic int run_len(input col_cmd_t c);
    return (c.length > MAX_RUN) ? MAX_RUN : int'(c.length);
  endfunction

  function automatic logic [TEXEL_AW-1:0] texel_at(input col_cmd_t c, input int i);
    logic [63:0] pos;
    logic [63:0] tsum;
    pos = 64'(c.start_fraction) + 64'(i) * 64'(c.step);
    tsum = 64'(c.source_offset) + (pos >> FRAC_BITS);
    return tsum[TEXEL_AW-1:0];
  endfunction

  task automatic predict_pixels(input col_cmd_t c);
    logic [63:0]      row_y;
    logic [63:0]      addr;
    logic [VAL_W-1:0] v;
    pix_t             p;
    int               n;
    int               i;
    case (c.kind)
      CMD_LOAD_TEXEL: begin
        texels[c.load_index[TEXEL_AW-1:0]] = c.load_value;
        texel_set[c.load_index[TEXEL_AW-1:0]] = 1'b1;
      end
      CMD_LOAD_SHADE: begin
        shades[c.load_index[SHADE_AW-1:0]] = c.load_value;
        shade_set[c.load_index[SHADE_AW-1:0]] = 1'b1;
      end
      default: begin
        n = run_len(c);
        for (i = 0; i < n; i++) begin
          v = texels[texel_at(c, i)];
          if (c.kind == CMD_DRAW_LIT) v = shades[v[SHADE_AW-1:0]];
          row_y = 64'(c.row_top) + 64'(c.row_shift) + 64'(i);
          addr = 64'(fb_cfg) + 64'(c.column) + row_y * 64'(sw_cfg);
          p.write_address = addr[ADDR_W-1:0];
          p.pixel = v;
          p.pixel_x = c.column;
          p.pixel_y = row_y[Y_W-1:0];
          p.last = (i == n - 1);
          pixel_q.push_back(p);
        end
      end
    endcase
  endtask

  task automatic drain_pixels();
    s_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_cmd(input col_cmd_t c, input logic chk, input pix_t want);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= c.kind;
    s_tdata <= S_DATA_W'({c.row_shift, c.row_top, c.column, c.length, c.step,
                          c.start_fraction, c.source_offset, c.load_value, c.load_index});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (chk) pixel_q.push_back(want);
    else predict_pixels(c);
    gap = send_gaps ? idle_len() : 0;
    if ($urandom_range(0, 59) == 0) begin
      drain_pixels();
    end else if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic col_cmd_t any_item(input cmd_t k);
    col_cmd_t c;
    c.kind = k;
    c.load_index = IDX_W'($urandom);
    c.load_value = VAL_W'($urandom);
    c.source_offset = IDX_W'($urandom);
    c.start_fraction = FRAC_W'($urandom);
    c.step = FRAC_W'($urandom);
    c.length = LEN_W'($urandom);
    c.column = COORD_W'($urandom);
    c.row_top = COORD_W'($urandom);
    c.row_shift = COORD_W'($urandom);
    return c;
  endfunction

  // load every texel and shade entry the draw will read that holds nothing yet
  task automatic fill_reads(input col_cmd_t c);
    col_cmd_t            f;
    logic [TEXEL_AW-1:0] ti;
    int                  i;
    for (i = 0; i < run_len(c); i++) begin
      ti = texel_at(c, i);
      if (!texel_set[ti]) begin
        f = any_item(CMD_LOAD_TEXEL);
        f.load_index = ti;
        send_cmd(f, 1'b0, '0);
      end
      if (c.kind == CMD_DRAW_LIT && !shade_set[texels[ti]]) begin
        f = any_item(CMD_LOAD_SHADE);
        f.load_index[SHADE_AW-1:0] = texels[ti];
        send_cmd(f, 1'b0, '0);
      end
    end
  endtask

  // draws mostly read a small texel window across the wrap point to keep loads few
  task automatic random_item();
    col_cmd_t            c;
    logic [TEXEL_AW-1:0] first;
    int                  r;
    int                  rs;
    r = $urandom_range(0, 9);
    if (r < 1) begin
      c = any_item(CMD_LOAD_TEXEL);
      c.load_index = WIN_BASE + IDX_W'($urandom_range(0, 31));
      send_cmd(c, 1'b0, '0);
    end else if (r < 2) begin
      send_cmd(any_item(CMD_LOAD_TEXEL), 1'b0, '0);
    end else if (r < 3) begin
      send_cmd(any_item(CMD_LOAD_SHADE), 1'b0, '0);
    end else begin
      c = any_item((r < 6) ? CMD_DRAW_LIT : CMD_DRAW_PLAIN);
      first = WIN_BASE + TEXEL_AW'($urandom_range(0, 15));
      c.start_fraction[FRAC_W-1:FRAC_BITS] = first - c.source_offset;
      r = $urandom_range(0, 9);
      if (r < 1) c.step = '0;
      else if (r < 8) c.step = FRAC_W'($urandom_range(0, 32'h3FFF));
      rs = $urandom_range(0, 19);
      if (r >= 8) c.length = LEN_W'($urandom_range(0, 2));
      else if (rs < 2) c.length = '0;
      else if (rs < 5) c.length = LEN_W'($urandom_range(MAX_RUN + 1, 127));
      else if (rs < 8) c.length = LEN_W'($urandom_range(1, 4));
      else c.length = LEN_W'($urandom_range(1, MAX_RUN));
      fill_reads(c);
      send_cmd(c, 1'b0, '0);
    end
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic idx, input logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== want) note_error($sformatf("register %0d read %08h, expected %08h", idx, rd, want));
  endtask

  task automatic set_reg(input logic idx, input logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, idx, val, rd);
    if (idx == REG_FRAME_BASE) fb_cfg = val[FB_W-1:0];
    else sw_cfg = val[SW_W-1:0];
    check_reg(idx, (idx == REG_FRAME_BASE) ? PDATA_W'(fb_cfg) : PDATA_W'(sw_cfg));
  endtask

  task automatic tab(input cmd_t k, input logic [IDX_W-1:0] li, input logic [VAL_W-1:0] lv,
                     input logic [IDX_W-1:0] src, input logic [FRAC_W-1:0] frac,
                     input logic [FRAC_W-1:0] st, input logic [LEN_W-1:0] len,
                     input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] rt,
                     input logic [COORD_W-1:0] rs, input logic chk, input pix_t want);
    dir_row_t d;
    d.c = '{k, li, lv, src, frac, st, len, col, rt, rs};
    d.chk = chk;
    d.want = want;
    dir_tab.push_back(d);
  endtask

  task automatic check_pixel();
    pix_t got;
    pix_t want;
    // m_tdata: write_address, pixel, pixel_x, pixel_y from bit 0 up
    got = {m_tdata[25:0], m_tdata[33:26], m_tdata[45:34], m_tdata[58:46], m_tlast};
    if (pixel_q.size() == 0) begin
      note_error({"unexpected pixel ", fmt_pix(got)});
    end else begin
      want = pixel_q.pop_front();
      if (got !== want) note_error({"pixel mismatch: expected ", fmt_pix(want),
                                    ", got ", fmt_pix(got)});
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_pixel();
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_left = sink_gaps ? idle_len() : 0;
      m_tready <= (stall_left == 0);
    end
  end

  initial begin
    logic [PDATA_W-1:0] fb_val;
    logic [PDATA_W-1:0] sw_val;
    int                 ph;
    int                 k;

    tab(CMD_LOAD_TEXEL, 12'h000, 8'hA5, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    tab(CMD_LOAD_TEXEL, 12'hFFF, 8'h5A, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    tab(CMD_LOAD_TEXEL, 12'h001, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    tab(CMD_LOAD_TEXEL, 12'h002, 8'h00, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    tab(CMD_LOAD_SHADE, 12'hFA5, 8'h3C, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    tab(CMD_LOAD_SHADE, 12'h05A, 8'hC3, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    tab(CMD_LOAD_SHADE, 12'hFFF, 8'h81, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    tab(CMD_LOAD_SHADE, 12'h000, 8'h7E, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    tab(CMD_DRAW_PLAIN, 0, 0, 12'h000, 0, 0, 1, 0, 0, 0, 1'b1,
        {26'd0, 8'hA5, 12'd0, 13'd0, 1'b1});
    tab(CMD_DRAW_LIT, 0, 0, 12'h000, 0, 0, 1, 0, 0, 0, 1'b1,
        {26'd0, 8'h3C, 12'd0, 13'd0, 1'b1});
    tab(CMD_DRAW_PLAIN, 0, 0, 12'hFFF, 0, 0, 1, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1,
        {26'd2624895, 8'h5A, 12'd4095, 13'd8190, 1'b1});
    tab(CMD_DRAW_LIT, 0, 0, 12'hFFF, 0, 0, 1, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1,
        {26'd2624895, 8'hC3, 12'd4095, 13'd8190, 1'b1});
    tab(CMD_DRAW_PLAIN, 0, 0, 12'hFFF, 0, 28'h10000, 4, 5, 10, 3, 1'b0, '0);
    tab(CMD_DRAW_LIT, 0, 0, 12'h000, 0, 0, 0, 9, 9, 9, 1'b0, '0);
    tab(CMD_DRAW_PLAIN, 0, 0, 12'h000, 0, 0, 127, 100, 0, 0, 1'b0, '0);
    tab(CMD_DRAW_LIT, 0, 0, 12'hFFF, 28'hFFFF, 1, 64, 7, 200, 50, 1'b0, '0);
    tab(CMD_DRAW_PLAIN, 0, 0, 12'h001, 0, 28'hFFFFFFF, 2, 1, 2, 3, 1'b0, '0);
    tab(CMD_DRAW_PLAIN, 0, 0, 12'h001, 28'hFFFFFFF, 28'h10000, 2, 4, 5, 6, 1'b0, '0);
    tab(CMD_DRAW_LIT, 0, 0, 12'h001, 0, 28'h10000, 2, 8, 9, 10, 1'b0, '0);
    tab(CMD_DRAW_PLAIN, 0, 0, 12'h002, 0, 0, 64, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_reg(REG_FRAME_BASE, PDATA_W'(FRAME_BASE_RESET));
    check_reg(REG_SCREEN_WIDTH, PDATA_W'(SCREEN_WIDTH_RESET));

    foreach (dir_tab[i]) send_cmd(dir_tab[i].c, dir_tab[i].chk, dir_tab[i].want);

    for (ph = 0; ph < 6; ph++) begin
      drain_pixels();
      case (ph)
        0: begin fb_val = 32'hFFFF_FFFF; sw_val = 32'hFFFF_FFFF; end
        1: begin fb_val = '0; sw_val = '0; end
        2: begin fb_val = $urandom; sw_val = 1; end
        3: begin fb_val = $urandom; sw_val = 4096; end
        4: begin fb_val = $urandom; sw_val = $urandom_range(1, 8191); end
        default: begin fb_val = '0; sw_val = 320; end
      endcase
      set_reg(REG_FRAME_BASE, fb_val);
      set_reg(REG_SCREEN_WIDTH, sw_val);
      send_gaps = (ph != 0);
      sink_gaps = (ph != 0) && (ph != 4);
      for (k = 0; k < NRAND; k++) random_item();
    end

    drain_pixels();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS scaled_texture_column_draw_unit");
    end else begin
      $display("FAIL scaled_texture_column_draw_unit");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/stcd_pkg.sv
rtl/stcd_front.sv
rtl/stcd_back.sv
rtl/scaled_texture_column_draw_unit.sv
tb/scaled_texture_column_draw_unit_tb.sv
